// File: hdl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// The macros expect a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/b2da_pkg.sv
// Types, constants and constant functions for the binary to decimal ASCII converter.
// Used by b2da_digit_stage and binary_to_decimal_ascii; depends on nothing.
package b2da_pkg;

  localparam int MaxDigits = 10;
  localparam int DigitCountDefault = 10;
  localparam int ValueWidth = 31;
  localparam int CmpWidth = 35;
  localparam int CountWidth = 4;
  localparam logic [5:0] AsciiZero = 6'd48;

  typedef logic [3:0] digit_t;

  // Work carried from one digit stage to the next.
  typedef struct packed {
    logic [ValueWidth-1:0]      rem;
    digit_t [MaxDigits-1:0]     digits;
    logic [CountWidth-1:0]      cnt;
  } stage_t;

  function automatic logic [63:0] pow10(input int p);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < p; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

// File: hdl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_digit_stage and assert_macros.svh.
//
// Usage: the slave channel (s_tvalid, s_tready, s_tdata) takes one non-negative
// integer per beat. The master channel (m_tvalid, m_tready, m_tdata, m_tlast)
// returns its decimal digits as ASCII characters, most significant first, one
// character per beat, with leading zeros dropped and tlast on the final one.
// Zero gives a single '0'. Values wider than DIGIT_COUNT digits show as all nines.
// The input register, DIGIT_COUNT digit stages and the character serializer form
// the pipeline, and an item passes through them in that order before its first
// character is presented. The serializer sends one character per cycle while
// m_tready is high, so an item of k digits takes k beats on the master channel,
// and the slave channel accepts one item per cycle while the pipeline has room.
// When the receiver stalls, every stage holds its data and fills up in turn
// before s_tready falls; nothing is dropped or repeated.
// Reset clears all valid bits; the block accepts input in the first cycle after.
`include "assert_macros.svh"

module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int DIGIT_COUNT = DigitCountDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [31:0] s_tdata,  // [30:0] value, [31] zero fill
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] digit_char, [7:6] zero fill
  output logic       m_tlast
);

  localparam int N = (DIGIT_COUNT >= 1 && DIGIT_COUNT <= MaxDigits) ? DIGIT_COUNT : MaxDigits;
  localparam logic [CmpWidth-1:0] Limit = CmpWidth'(pow10(N) - 64'd1);

  logic   chain_valid [0:N];
  logic   chain_ready [0:N];
  stage_t chain_data  [0:N];

  logic [ValueWidth-1:0] value_sat;
  stage_t                in_next;

  always_comb begin
    value_sat = s_tdata[ValueWidth-1:0];
    if ({{(CmpWidth-ValueWidth){1'b0}}, s_tdata[ValueWidth-1:0]} > Limit) begin
      value_sat = Limit[ValueWidth-1:0];
    end
    in_next.rem    = value_sat;
    in_next.digits = '0;
    in_next.cnt    = '0;
  end

  assign s_tready = !chain_valid[0] || chain_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (s_tready) begin
      chain_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      chain_data[0] <= in_next;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    b2da_digit_stage #(
      .POS(N - 1 - j)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[j]),
      .in_ready (chain_ready[j]),
      .in_data  (chain_data[j]),
      .out_valid(chain_valid[j+1]),
      .out_ready(chain_ready[j+1]),
      .out_data (chain_data[j+1])
    );
  end

  // Character serializer: digits are right aligned, remaining counts what is left.
  digit_t [MaxDigits-1:0] ser_digits;
  logic [CountWidth-1:0]  remaining;
  logic [CountWidth-1:0]  head_idx;
  logic                   ser_first;
  logic                   load;
  digit_t                 head;

  assign head_idx         = remaining - CountWidth'(1);
  assign head             = ser_digits[head_idx];
  assign m_tlast          = (remaining == CountWidth'(1));
  assign m_tdata          = {2'b00, AsciiZero + {2'b00, head}};
  assign chain_ready[N]   = !m_tvalid || (m_tready && m_tlast);
  assign load             = chain_ready[N] && chain_valid[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      remaining <= '0;
      ser_first <= 1'b0;
    end else if (chain_ready[N]) begin
      m_tvalid  <= chain_valid[N];
      ser_first <= chain_valid[N];
      if (chain_valid[N]) begin
        remaining <= (chain_data[N].cnt == '0) ? CountWidth'(1) : chain_data[N].cnt;
      end
    end else if (m_tready) begin
      remaining <= remaining - CountWidth'(1);
      ser_first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_digits <= chain_data[N].digits;
    end
  end

  `ASSERT_IMPLY(a_remaining_range, m_tvalid,
    remaining != '0 && remaining <= CountWidth'(N),
    "Serializer count out of range while a character is shown.")
  `ASSERT_IMPLY(a_no_leading_zero, m_tvalid && ser_first && !m_tlast,
    head != '0,
    "Leading zero emitted in a multi-digit run.")
  `ASSERT_NEXT(a_count_steps, m_tvalid && m_tready && !m_tlast,
    m_tvalid && remaining == $past(remaining) - CountWidth'(1),
    "Serializer did not advance by one character.")

endmodule

// File: hdl/b2da_digit_stage.sv
// One pipeline stage of the converter: extracts the decimal digit at position POS.
// Depends on b2da_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b2da_digit_stage
  import b2da_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stage_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output stage_t out_data
);

  localparam logic [CmpWidth-1:0] Step = CmpWidth'(pow10(POS));

  logic [CmpWidth-1:0] rem_ext;
  logic [CmpWidth-1:0] sub;
  digit_t              d;
  stage_t              data_next;

  assign in_ready = !out_valid || out_ready;
  assign rem_ext  = {{(CmpWidth-ValueWidth){1'b0}}, in_data.rem};

  always_comb begin
    d   = '0;
    sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_ext >= CmpWidth'(k) * Step) begin
        d   = 4'(k);
        sub = CmpWidth'(k) * Step;
      end
    end
    data_next     = in_data;
    data_next.rem = in_data.rem - sub[ValueWidth-1:0];
    if (d != '0 || in_data.cnt != '0) begin
      data_next.digits = {in_data.digits[MaxDigits-2:0], d};
      data_next.cnt    = in_data.cnt + CountWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

  `ASSERT_IMPLY(a_rem_below_step, out_valid,
    {{(CmpWidth-ValueWidth){1'b0}}, out_data.rem} < Step,
    "Remainder not below the digit weight after extraction.")
  `ASSERT_IMPLY(a_lead_nonzero, out_valid && out_data.cnt != '0,
    out_data.digits[out_data.cnt - CountWidth'(1)] != '0,
    "Leading stored digit is zero.")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for binary_to_decimal_ascii: drives integers on the slave stream
// and checks every master stream ASCII digit beat against given text or a digit predictor.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import b2da_pkg::AsciiZero;

  localparam int NumDigits = 10;
  localparam int DirectedCount = 18;
  localparam int RandomCount = 302;
  localparam longint unsigned ValueMax = 64'd2147483647;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } digit_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  digit_beat_t pending_chars[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          error_count = 0;
  int          values_sent = 0;
  int          chars_checked = 0;

  logic [30:0] directed_values [DirectedCount] = '{
    31'd0, 31'd1, 31'd9, 31'd10, 31'd100, 31'd999999999, 31'd1000000000,
    31'd1999999999, 31'd2000000000, 31'd2147483647, 31'd1073741824,
    31'd1234567890, 31'd1010101010, 31'h2AAA_AAAA, 31'h5555_5555,
    31'h7FFF_0000, 31'h0000_FFFF, 31'h7FFF_FFFE
  };
  string directed_text [DirectedCount] = '{
    "0", "1", "9", "10", "100", "999999999", "1000000000",
    "1999999999", "2000000000", "2147483647", "1073741824",
    "1234567890", "1010101010", "", "", "", "", ""
  };

  binary_to_decimal_ascii #(
    .DIGIT_COUNT(NumDigits)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned ten_to(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  task automatic predict_digits(input logic [30:0] value);
    longint unsigned rem;
    longint unsigned scale;
    longint unsigned d;
    bit              started;
    digit_beat_t     beat;
    started = 1'b0;
    rem = value;
    scale = ten_to(NumDigits - 1);
    if (rem > scale * 10 - 1) rem = scale * 10 - 1;
    if (rem == 0) begin
      beat.digit_char = AsciiZero;
      beat.last = 1'b1;
      pending_chars.push_back(beat);
    end else begin
      while (scale != 0) begin
        d = rem / scale;
        if (d > 9) d = 9;
        if (d != 0 || started) begin
          beat.digit_char = AsciiZero + 6'(d);
          beat.last = 1'b0;
          pending_chars.push_back(beat);
          rem = rem - d * scale;
          started = 1'b1;
        end
        scale = scale / 10;
      end
      pending_chars[pending_chars.size() - 1].last = 1'b1;
    end
  endtask

  function automatic logic [30:0] random_value();
    int              kind;
    int              len;
    longint unsigned lo;
    longint unsigned hi;
    kind = $urandom_range(9, 0);
    if (kind == 0) return '0;
    if (kind <= 2) return 31'($urandom_range(32'h7FFF_FFFF, 0));
    if (kind == 3) return 31'($urandom_range(9, 1) * ten_to($urandom_range(8, 0)));
    len = $urandom_range(NumDigits, 1);
    lo = ten_to(len - 1);
    hi = ten_to(len) - 1;
    if (hi > ValueMax) hi = ValueMax;
    return 31'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  // An empty text means the expected digits come from the predictor.
  task automatic send_value(input logic [30:0] value, input string text);
    digit_beat_t beat;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= {1'b0, 31'($urandom())};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    values_sent++;
    if (text.len() == 0) begin
      predict_digits(value);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        beat.digit_char = 6'(text[i]);
        beat.last = (i == text.len() - 1);
        pending_chars.push_back(beat);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    digit_beat_t expected;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        expected = pending_chars.pop_front();
        chars_checked++;
        if (m_tdata !== {2'b00, expected.digit_char}) begin
          $display("%0t: tdata mismatch, expected %h actual %h", $time,
                   {2'b00, expected.digit_char}, m_tdata);
          error_count++;
        end
        if (m_tlast !== expected.last) begin
          $display("%0t: tlast mismatch, expected %b actual %b", $time,
                   expected.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 61;
    for (int i = 0; i < DirectedCount; i++) begin
      send_value(directed_values[i], directed_text[i]);
    end
    for (int i = 0; i < RandomCount; i++) begin
      if (i == RandomCount / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 31;
      end else if (i == 2 * RandomCount / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_value(random_value(), "");
    end
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (NumDigits + 4) @(posedge clk);
    $display("Converted %0d values into %0d checked digit beats under three stall mixes.",
             values_sent, chars_checked);
    $display("Mismatches seen: %0d.", error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/b2da_pkg.sv
hdl/b2da_digit_stage.sv
hdl/binary_to_decimal_ascii.sv
verif/testbench.sv
